### rtl/ilirs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilirs_pkg
// Types and constants shared by the indexed list blocks.
// ----------------------------------------------------------------------------
package ilirs_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam logic [2:0] REQ_APPEND  = 3'd0;
    localparam logic [2:0] REQ_INSERT  = 3'd1;
    localparam logic [2:0] REQ_EXTRACT = 3'd2;
    localparam logic [2:0] REQ_SEARCH  = 3'd3;
    localparam logic [2:0] REQ_DELETE  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    localparam logic [1:0] CMD_HOLD     = 2'd0;
    localparam logic [1:0] CMD_INSERT   = 2'd1;
    localparam logic [1:0] CMD_SHIFT_DN = 2'd2;

    typedef struct packed {
        logic [2:0]                  req_type;
        logic [IDX_W-1:0]            position;
        logic signed [WORD_BITS-1:0] value;
        logic [CNT_W-1:0]            run_length;
    } req_t;

    typedef struct packed {
        logic [1:0]                  status;
        logic signed [WORD_BITS-1:0] data_out;
        logic [IDX_W-1:0]            found_position;
        logic [CNT_W-1:0]            length;
    } rsp_t;

    typedef struct packed {
        logic [1:0]                  cmd;
        logic [IDX_W-1:0]            pos;
        logic signed [WORD_BITS-1:0] value;
    } cell_ctrl_t;

endpackage

### rtl/ilirs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilirs_cell
// One list slot: holds an entry, shifts with its neighbors, compares.
// ----------------------------------------------------------------------------
module ilirs_cell (
    input  logic                                   clk,
    input  ilirs_pkg::cell_ctrl_t                  ctrl,
    input  logic [ilirs_pkg::IDX_W-1:0]            idx,
    input  logic signed [ilirs_pkg::WORD_BITS-1:0] prev_data,
    input  logic signed [ilirs_pkg::WORD_BITS-1:0] next_data,
    output logic signed [ilirs_pkg::WORD_BITS-1:0] data,
    output logic signed [ilirs_pkg::WORD_BITS-1:0] sel_data,
    output logic                                   match
);

    logic signed [ilirs_pkg::WORD_BITS-1:0] data_reg;
    logic signed [ilirs_pkg::WORD_BITS-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.cmd)
            ilirs_pkg::CMD_INSERT:
            begin
                if (idx == ctrl.pos)
                begin
                    data_next = ctrl.value;
                end
                else if (idx > ctrl.pos)
                begin
                    data_next = prev_data;
                end
            end
            ilirs_pkg::CMD_SHIFT_DN:
            begin
                if (idx >= ctrl.pos)
                begin
                    data_next = next_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = (idx == ctrl.pos) ? data_reg : '0;
    assign match    = (data_reg == ctrl.value);

endmodule

### rtl/indexed_list_insert_remove_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_search
// Ordered list of signed words in a chain of cells, with a length count.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------
//  request | req_valid, req_ready | req (req_t)
//  result  | rsp_valid, rsp_ready | rsp (rsp_t)
//
//  Append, insert, extract, search and refused requests complete without
//  leaving the idle state. A delete run shifts the chain down by one slot
//  each cycle, one removed entry at a time; a run of zero removes nothing.
//  A new request is taken when idle, once the result register is free or
//  being drained. Reset clears the length; entries need no clearing.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_search (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ilirs_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ilirs_pkg::rsp_t   rsp
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_DELETE = 1'b1;

    localparam int DEPTH = ilirs_pkg::DEPTH;
    localparam int IDX_W = ilirs_pkg::IDX_W;
    localparam int CNT_W = ilirs_pkg::CNT_W;
    localparam int WB    = ilirs_pkg::WORD_BITS;

    logic                  state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      left_reg, left_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic                  rsp_valid_reg;
    ilirs_pkg::rsp_t       rsp_reg, rsp_next;
    logic                  rsp_load;
    logic                  accept;

    ilirs_pkg::cell_ctrl_t ctrl;
    logic signed [WB-1:0]  cell_data [DEPTH];
    logic signed [WB-1:0]  cell_sel  [DEPTH];
    logic [DEPTH-1:0]      cell_match;
    logic [DEPTH-1:0]      hit_vec;
    logic                  hit_any;
    logic [IDX_W-1:0]      hit_pos;
    logic signed [WB-1:0]  sel_word;
    logic [CNT_W-1:0]      pos_ext;
    logic [CNT_W-1:0]      tail;
    logic [CNT_W-1:0]      eff_run;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic signed [WB-1:0] prev_w;
            logic signed [WB-1:0] next_w;
            if (g == 0)
            begin : g_first
                assign prev_w = '0;
            end
            else
            begin : g_mid_prev
                assign prev_w = cell_data[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign next_w = '0;
            end
            else
            begin : g_mid_next
                assign next_w = cell_data[g+1];
            end
            ilirs_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .idx       (IDX_W'(g)),
                .prev_data (prev_w),
                .next_data (next_w),
                .data      (cell_data[g]),
                .sel_data  (cell_sel[g]),
                .match     (cell_match[g])
            );
            assign hit_vec[g] = cell_match[g] && (CNT_W'(g) < count_reg);
        end
    endgenerate

    always_comb
    begin
        hit_pos  = '0;
        sel_word = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_pos = IDX_W'(i);
            end
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_word = sel_word | cell_sel[i];
        end
    end

    assign hit_any   = |hit_vec;
    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign pos_ext   = {1'b0, req.position};
    assign tail      = count_reg - pos_ext;
    assign eff_run   = (req.run_length > tail) ? tail : req.run_length;

    always_comb
    begin
        ctrl.cmd                = ilirs_pkg::CMD_HOLD;
        ctrl.pos                = req.position;
        ctrl.value              = req.value;
        state_next              = state_reg;
        count_next              = count_reg;
        left_next               = left_reg;
        pos_next                = pos_reg;
        rsp_load                = 1'b0;
        rsp_next.status         = ilirs_pkg::ST_OK;
        rsp_next.data_out       = '0;
        rsp_next.found_position = '0;

        if (state_reg == S_DELETE)
        begin
            ctrl.cmd   = ilirs_pkg::CMD_SHIFT_DN;
            ctrl.pos   = pos_reg;
            count_next = count_reg - CNT_W'(1);
            left_next  = left_reg - CNT_W'(1);
            if (left_reg == CNT_W'(1))
            begin
                state_next = S_IDLE;
                rsp_load   = 1'b1;
            end
        end
        else if (accept)
        begin
            rsp_load = 1'b1;
            case (req.req_type)
                ilirs_pkg::REQ_APPEND:
                begin
                    if (count_reg >= CNT_W'(DEPTH))
                    begin
                        rsp_next.status = ilirs_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.cmd   = ilirs_pkg::CMD_INSERT;
                        ctrl.pos   = count_reg[IDX_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ilirs_pkg::REQ_INSERT:
                begin
                    if (pos_ext > count_reg)
                    begin
                        rsp_next.status = ilirs_pkg::ST_RANGE;
                    end
                    else if (count_reg >= CNT_W'(DEPTH))
                    begin
                        rsp_next.status = ilirs_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.cmd   = ilirs_pkg::CMD_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ilirs_pkg::REQ_EXTRACT:
                begin
                    if (pos_ext >= count_reg)
                    begin
                        rsp_next.status = ilirs_pkg::ST_RANGE;
                    end
                    else
                    begin
                        ctrl.cmd          = ilirs_pkg::CMD_SHIFT_DN;
                        rsp_next.data_out = sel_word;
                        count_next        = count_reg - CNT_W'(1);
                    end
                end
                ilirs_pkg::REQ_SEARCH:
                begin
                    if (hit_any)
                    begin
                        rsp_next.found_position = hit_pos;
                    end
                    else
                    begin
                        rsp_next.status = ilirs_pkg::ST_MISS;
                    end
                end
                ilirs_pkg::REQ_DELETE:
                begin
                    if (pos_ext >= count_reg)
                    begin
                        rsp_next.status = ilirs_pkg::ST_RANGE;
                    end
                    else if (eff_run != '0)
                    begin
                        ctrl.cmd   = ilirs_pkg::CMD_SHIFT_DN;
                        count_next = count_reg - CNT_W'(1);
                        if (eff_run != CNT_W'(1))
                        begin
                            rsp_load   = 1'b0;
                            state_next = S_DELETE;
                            left_next  = eff_run - CNT_W'(1);
                            pos_next   = req.position;
                        end
                    end
                end
                default:
                begin
                    rsp_next.status = ilirs_pkg::ST_OK;
                end
            endcase
        end
        rsp_next.length = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/ilirs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilirs_checker
// Port-level checks for the indexed list, bound to the top level.
// ----------------------------------------------------------------------------
module ilirs_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input ilirs_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.length <= ilirs_pkg::CNT_W'(ilirs_pkg::DEPTH))
        else $error("length beyond depth");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ilirs_pkg::ST_FULL
            |-> rsp.length == ilirs_pkg::CNT_W'(ilirs_pkg::DEPTH))
        else $error("full status on a list that is not full");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ilirs_pkg::ST_OK
            |-> rsp.data_out == '0 && rsp.found_position == '0)
        else $error("refused item carries data");

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> !rsp_valid || rsp_ready)
        else $error("item taken while result register is blocked");

endmodule

bind indexed_list_insert_remove_search ilirs_checker u_ilirs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

### sim/indexed_list_insert_remove_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_search_tb
// Self-checking regression for the indexed list block.
// A short table of directed requests covers the empty and full list, the
// word extremes, out-of-range positions, run clipping and spare request
// codes. Random traffic follows in growing and shrinking phases, so the list
// fills and drains many times. Every result is checked against the table's
// expected reply or a list model kept in step with the accepted requests.
// The sender and the receiver both idle at random.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_search_tb;

    import ilirs_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int DRAIN_EVERY    = 500;
    localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [2:0] REQ_SPARE_LO  = 3'd5;
    localparam logic [2:0] REQ_SPARE_MID = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI  = 3'd7;

    localparam int RX_STEADY = 0;
    localparam int RX_CHOPPY = 1;
    localparam int RX_LONG   = 2;

    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

    typedef struct {
        req_t item;
        int   reps;
        bit   typed;
        rsp_t reply;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    logic signed [WORD_BITS-1:0] list_words [DEPTH];
    int       list_len = 0;
    rsp_t     reply_queue [$];
    dir_row_t dir_rows [$];

    int errors       = 0;
    int replies_seen = 0;
    int quiet_cycles = 0;
    int burst_left   = 0;
    bit steady       = 1'b0;
    bit growing      = 1'b1;
    int rx_mode      = RX_STEADY;
    int seg_left     = 0;
    int hold_left    = 0;

    indexed_list_insert_remove_search u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic report_mismatch(string field, logic [WORD_BITS-1:0] want_v,
                                   logic [WORD_BITS-1:0] got_v);
        errors++;
        $display("%0t: result %0d: %s expected %0h, got %0h",
                 $realtime, replies_seen, field, want_v, got_v);
    endtask

    function automatic void drop_span(int first, int n);
        for (int i = first; i + n < list_len; i++)
            list_words[i] = list_words[i + n];
        list_len -= n;
    endfunction

    function automatic rsp_t apply_list_request(req_t r);
        rsp_t res;
        int   pos;
        int   run;
        res = '0;
        pos = int'(r.position);
        run = int'(r.run_length);
        case (r.req_type)
            REQ_APPEND:
            begin
                if (list_len >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    list_words[list_len] = r.value;
                    list_len++;
                end
            end
            REQ_INSERT:
            begin
                if (pos > list_len)
                    res.status = ST_RANGE;
                else if (list_len >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = list_len; i > pos; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[pos] = r.value;
                    list_len++;
                end
            end
            REQ_EXTRACT:
            begin
                if (pos >= list_len)
                    res.status = ST_RANGE;
                else
                begin
                    res.data_out = list_words[pos];
                    drop_span(pos, 1);
                end
            end
            REQ_SEARCH:
            begin
                res.status = ST_MISS;
                for (int i = 0; i < list_len; i++)
                begin
                    if (res.status == ST_MISS && list_words[i] == r.value)
                    begin
                        res.status         = ST_OK;
                        res.found_position = IDX_W'(i);
                    end
                end
            end
            REQ_DELETE:
            begin
                if (pos >= list_len)
                    res.status = ST_RANGE;
                else
                begin
                    if (run > list_len - pos)
                        run = list_len - pos;
                    drop_span(pos, run);
                end
            end
            default:
            begin
            end
        endcase
        res.length = CNT_W'(list_len);
        return res;
    endfunction

    function automatic logic signed [WORD_BITS-1:0] draw_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return WORD_BITS'(int'($urandom_range(0, 7)) - 4);
        if (pick < 55)
        begin
            case ($urandom_range(0, 3))
                0:       return WORD_MIN;
                1:       return WORD_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        return WORD_BITS'($urandom);
    endfunction

    function automatic req_t draw_request();
        req_t r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < (growing ? 30 : 8))
            r.req_type = REQ_APPEND;
        else if (pick < (growing ? 60 : 16))
            r.req_type = REQ_INSERT;
        else if (pick < (growing ? 68 : 51))
            r.req_type = REQ_EXTRACT;
        else if (pick < (growing ? 85 : 68))
            r.req_type = REQ_SEARCH;
        else if (pick < 98)
            r.req_type = REQ_DELETE;
        else
            r.req_type = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));

        r.position = IDX_W'($urandom_range(0, DEPTH - 1));
        if ($urandom_range(0, 99) < 85)
        begin
            if (r.req_type == REQ_INSERT)
                r.position = IDX_W'($urandom_range(0, (list_len < DEPTH) ? list_len : DEPTH - 1));
            else if (list_len != 0)
                r.position = IDX_W'($urandom_range(0, list_len - 1));
        end

        r.value = draw_word();
        if (r.req_type == REQ_SEARCH && list_len != 0 && $urandom_range(0, 9) < 6)
            r.value = list_words[$urandom_range(0, list_len - 1)];

        pick = $urandom_range(0, 9);
        if (pick < 7)
            r.run_length = CNT_W'($urandom_range(1, 4));
        else if (pick == 7)
            r.run_length = '0;
        else
            r.run_length = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
        return r;
    endfunction

    function automatic void add_row(logic [2:0] op, int pos, logic [WORD_BITS-1:0] val,
                                    int run, int reps, bit typed, logic [1:0] st,
                                    logic [WORD_BITS-1:0] dout, int fpos, int len);
        dir_row_t row;
        row.item.req_type         = op;
        row.item.position         = IDX_W'(pos);
        row.item.value            = val;
        row.item.run_length       = CNT_W'(run);
        row.reps                  = reps;
        row.typed                 = typed;
        row.reply.status          = st;
        row.reply.data_out        = dout;
        row.reply.found_position  = IDX_W'(fpos);
        row.reply.length          = CNT_W'(len);
        dir_rows.push_back(row);
    endfunction

    task automatic idle_sender(int n);
        repeat (n)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
    endtask

    task automatic pace_sender();
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 5) == 0)
                steady = ~steady;
            burst_left = $urandom_range(1, 24);
            if (!steady)
                idle_sender($urandom_range(1, 8));
        end
        burst_left--;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (reply_queue.size() != 0)
            @(negedge clk);
    endtask

    task automatic issue_request(req_t r, bit typed, rsp_t typed_reply);
        rsp_t predicted;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = apply_list_request(r);
        reply_queue.push_back(typed ? typed_reply : predicted);
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (seg_left == 0)
        begin
            rx_mode  = $urandom_range(RX_STEADY, RX_LONG);
            seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (rx_mode)
            RX_STEADY:
                rsp_ready <= 1'b1;
            RX_CHOPPY:
                rsp_ready <= 1'($urandom_range(0, 1));
            default:
            begin
                if (hold_left != 0)
                begin
                    hold_left--;
                    rsp_ready <= 1'b0;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    hold_left = $urandom_range(1, 30);
                    rsp_ready <= 1'b0;
                end
                else
                    rsp_ready <= 1'b1;
            end
        endcase
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            replies_seen++;
            if (reply_queue.size() == 0)
                report_mismatch("result with nothing outstanding, length", '0, rsp.length);
            else
            begin
                want = reply_queue.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", want.status, rsp.status);
                if (rsp.data_out !== want.data_out)
                    report_mismatch("data_out", want.data_out, rsp.data_out);
                if (rsp.found_position !== want.found_position)
                    report_mismatch("found_position", want.found_position, rsp.found_position);
                if (rsp.length !== want.length)
                    report_mismatch("length", want.length, rsp.length);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("indexed_list_insert_remove_search regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t row;
        req_t     r;

        add_row(REQ_EXTRACT, 0, 0, 0, 1, 1'b1, ST_RANGE, 0, 0, 0);
        add_row(REQ_SEARCH, 0, 0, 0, 1, 1'b1, ST_MISS, 0, 0, 0);
        add_row(REQ_DELETE, 0, 0, 1, 1, 1'b1, ST_RANGE, 0, 0, 0);
        add_row(REQ_INSERT, 1, 5, 0, 1, 1'b1, ST_RANGE, 0, 0, 0);
        add_row(REQ_INSERT, 0, WORD_MIN, 0, 1, 1'b1, ST_OK, 0, 0, 1);
        add_row(REQ_APPEND, 0, WORD_MAX, 0, 1, 1'b1, ST_OK, 0, 0, 2);
        add_row(REQ_INSERT, 2, -1, 0, 1, 1'b1, ST_OK, 0, 0, 3);
        add_row(REQ_INSERT, 0, 0, 0, 1, 1'b1, ST_OK, 0, 0, 4);
        add_row(REQ_SEARCH, 0, WORD_MIN, 0, 1, 1'b1, ST_OK, 0, 1, 4);
        add_row(REQ_SEARCH, 0, -1, 0, 1, 1'b1, ST_OK, 0, 3, 4);
        add_row(REQ_SEARCH, 0, 12345, 0, 1, 1'b1, ST_MISS, 0, 0, 4);
        add_row(REQ_EXTRACT, 3, 0, 0, 1, 1'b1, ST_OK, -1, 0, 3);
        add_row(REQ_EXTRACT, 3, 0, 0, 1, 1'b1, ST_RANGE, 0, 0, 3);
        add_row(REQ_SPARE_LO, 0, 0, 0, 1, 1'b1, ST_OK, 0, 0, 3);
        add_row(REQ_SPARE_HI, DEPTH - 1, -1, (1 << CNT_W) - 1, 1, 1'b1, ST_OK, 0, 0, 3);
        add_row(REQ_DELETE, 1, 0, 0, 1, 1'b1, ST_OK, 0, 0, 3);
        add_row(REQ_DELETE, DEPTH - 1, 0, 1, 1, 1'b1, ST_RANGE, 0, 0, 3);
        add_row(REQ_DELETE, 1, 0, (1 << CNT_W) - 1, 1, 1'b1, ST_OK, 0, 0, 1);
        add_row(REQ_EXTRACT, 0, 0, 0, 1, 1'b1, ST_OK, 0, 0, 0);
        add_row(REQ_APPEND, 0, 0, 0, DEPTH, 1'b0, ST_OK, 0, 0, 0);
        add_row(REQ_APPEND, 0, 1, 0, 1, 1'b1, ST_FULL, 0, 0, DEPTH);
        add_row(REQ_INSERT, DEPTH - 1, 2, 0, 1, 1'b1, ST_FULL, 0, 0, DEPTH);
        add_row(REQ_INSERT, 0, 3, 0, 1, 1'b1, ST_FULL, 0, 0, DEPTH);
        add_row(REQ_SEARCH, 0, 0, 0, 1, 1'b0, ST_OK, 0, 0, 0);
        add_row(REQ_EXTRACT, DEPTH - 1, 0, 0, 1, 1'b0, ST_OK, 0, 0, 0);
        add_row(REQ_INSERT, DEPTH - 1, WORD_MAX, 0, 1, 1'b1, ST_OK, 0, 0, DEPTH);
        add_row(REQ_DELETE, 0, 0, DEPTH, 1, 1'b1, ST_OK, 0, 0, 0);
        add_row(REQ_SPARE_MID, 0, 0, 0, 1, 1'b1, ST_OK, 0, 0, 0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k])
        begin
            row = dir_rows[k];
            for (int n = 0; n < row.reps; n++)
            begin
                r = row.item;
                if (row.reps > 1)
                    r.value = draw_word();
                pace_sender();
                issue_request(r, row.typed, row.reply);
            end
        end
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n != 0 && n % DRAIN_EVERY == 0)
                wait_drained();
            if (growing && list_len == DEPTH && $urandom_range(0, 7) == 0)
                growing = 1'b0;
            else if (!growing && list_len == 0 && $urandom_range(0, 3) == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 149) == 0)
                growing = ~growing;
            pace_sender();
            issue_request(draw_request(), 1'b0, '0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && reply_queue.size() == 0)
            $display("indexed_list_insert_remove_search regression: pass");
        else
            $display("indexed_list_insert_remove_search regression: fail");
        $finish;
    end

endmodule

### indexed_list_insert_remove_search.f
rtl/ilirs_pkg.sv
rtl/ilirs_cell.sv
rtl/indexed_list_insert_remove_search.sv
rtl/ilirs_checker.sv
sim/indexed_list_insert_remove_search_tb.sv
